FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define RTD_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("rtd assertion failed");

// a implies b in the following cycle
`define RTD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("rtd assertion failed");

`endif

FILE: design/rtd_pkg.sv
// types, command codes and helpers of the ring termination detector
// no dependencies
package rtd_pkg;

   localparam int NODE_ID_W = 4;
   localparam int COUNT_W   = 16;

   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_TOKEN     = 3'd1,
      CMD_TERMINATE = 3'd2,
      CMD_ACTIVE    = 3'd3,
      CMD_PASSIVE   = 3'd4,
      CMD_SEND      = 3'd5,
      CMD_RECEIVE   = 3'd6,
      CMD_RESTART   = 3'd7
   } cmd_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic [NODE_ID_W-1:0]        peer;
      logic signed [COUNT_W-1:0]   token_in_count;
      logic                        token_in_black;
   } req_type;

   typedef struct packed {
      logic                        token_out_valid;
      logic signed [COUNT_W-1:0]   token_out_count;
      logic                        token_out_black;
      logic                        broadcast_terminate;
      logic                        finished;
   } rsp_type;

   // saturating signed add
   function automatic logic signed [COUNT_W-1:0] sat_add(
      input logic signed [COUNT_W-1:0] a,
      input logic signed [COUNT_W-1:0] b
   );
      logic signed [COUNT_W:0] s;
      s = {a[COUNT_W-1], a} + {b[COUNT_W-1], b};
      if (s[COUNT_W] != s[COUNT_W-1]) begin
         return s[COUNT_W] ? {1'b1, {(COUNT_W-1){1'b0}}} : {1'b0, {(COUNT_W-1){1'b1}}};
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

FILE: design/ring_termination_detector.sv
// One node of a token ring termination detector.
// Channels: req_ (valid/ready) carries one event word: command, send peer and,
// for a token arrival, the token count and color. rsp_ (valid/ready) returns
// exactly one word per event: an outgoing token (valid, count, color), the
// terminate broadcast of node 0 and the finished flag. csr_wr_en/csr_wr_data
// write the node id; write it only while the node is idle.
// Response path: the response word of an event passes the input register, then
// the response register, and stays on rsp_ until the receiver takes it.
// Throughput: one event per cycle while rsp_ready keeps the response register
// free, set by the combinational state update between the two registers.
// A waiting response blocks intake only when the input register is full: it
// keeps taking a word as long as the response register frees up; when the
// receiver holds rsp_ready low, both fill and req_ready drops after two words.
// Reset clears the node to white, passive, zero balance, no held token, not
// finished, node id 0.
// Depends on rtd_pkg.
module ring_termination_detector import rtd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_word,
   input  logic                  csr_wr_en,
   input  logic [NODE_ID_W-1:0]  csr_wr_data
);

   logic                        s1_valid_ff, s1_valid_in;
   req_type                     s1_word_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_word_ff, rsp_word_in;
   logic [NODE_ID_W-1:0]        node_id_ff;

   logic signed [COUNT_W-1:0]   balance_ff, balance_in;
   logic                        black_ff, black_in;
   logic                        active_ff, active_in;
   logic                        holding_ff, holding_in;
   logic signed [COUNT_W-1:0]   held_count_ff, held_count_in;
   logic                        held_black_ff, held_black_in;
   logic                        done_ff, done_in;

   logic                        s2_take, s1_move, req_take;
   logic                        is_node0;
   logic signed [COUNT_W-1:0]   base_count, tok_count;
   logic                        base_black;

   assign s2_take   = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_take;
   assign req_ready = !s1_valid_ff || s2_take;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_take ? s1_valid_ff : rsp_valid_ff;

   assign is_node0 = (node_id_ff == '0);

   // outgoing token: arriving token or the held one, node 0 restarts the wave
   always_comb begin
      base_count = (s1_word_ff.cmd == CMD_TOKEN) ? s1_word_ff.token_in_count : held_count_ff;
      base_black = (s1_word_ff.cmd == CMD_TOKEN) ? s1_word_ff.token_in_black : held_black_ff;
      if (is_node0) begin
         base_count = '0;
         base_black = 1'b0;
      end
      tok_count = sat_add(base_count, balance_ff);
   end

   always_comb begin
      balance_in    = balance_ff;
      black_in      = black_ff;
      active_in     = active_ff;
      holding_in    = holding_ff;
      held_count_in = held_count_ff;
      held_black_in = held_black_ff;
      done_in       = done_ff;
      rsp_word_in   = '0;
      if (!done_ff) begin
         unique case (s1_word_ff.cmd)
            CMD_START: begin
               rsp_word_in.token_out_valid = is_node0;
            end
            CMD_TOKEN: begin
               holding_in    = 1'b1;
               held_count_in = s1_word_ff.token_in_count;
               held_black_in = s1_word_ff.token_in_black;
               if (!active_ff) begin
                  holding_in = 1'b0;
                  if (is_node0 && !s1_word_ff.token_in_black
                      && s1_word_ff.token_in_count == '0) begin
                     done_in = 1'b1;
                     rsp_word_in.broadcast_terminate = 1'b1;
                  end else begin
                     rsp_word_in.token_out_valid = 1'b1;
                     rsp_word_in.token_out_count = tok_count;
                     rsp_word_in.token_out_black = base_black | black_ff;
                     black_in = 1'b0;
                  end
               end
            end
            CMD_TERMINATE: begin
               done_in = 1'b1;
            end
            CMD_ACTIVE: begin
               active_in = 1'b1;
            end
            CMD_PASSIVE: begin
               active_in = 1'b0;
               if (holding_ff) begin
                  holding_in = 1'b0;
                  rsp_word_in.token_out_valid = 1'b1;
                  rsp_word_in.token_out_count = tok_count;
                  rsp_word_in.token_out_black = base_black | black_ff;
                  black_in = 1'b0;
               end
            end
            CMD_SEND: begin
               balance_in = sat_add(balance_ff, COUNT_W'(1));
               if (node_id_ff > s1_word_ff.peer) begin
                  black_in = 1'b1;
               end
            end
            CMD_RECEIVE: begin
               balance_in = sat_add(balance_ff, {COUNT_W{1'b1}});
            end
            CMD_RESTART: begin
               black_in   = 1'b0;
               balance_in = '0;
            end
         endcase
      end
      rsp_word_in.finished = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_id_ff    <= '0;
         balance_ff    <= '0;
         black_ff      <= 1'b0;
         active_ff     <= 1'b0;
         holding_ff    <= 1'b0;
         held_count_ff <= '0;
         held_black_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_id_ff <= csr_wr_data;
         end
         if (s1_move) begin
            balance_ff    <= balance_in;
            black_ff      <= black_in;
            active_ff     <= active_in;
            holding_ff    <= holding_in;
            held_count_ff <= held_count_in;
            held_black_ff <= held_black_in;
            done_ff       <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
      if (s1_move) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

FILE: design/rtd_checker.sv
// port-level checks of the ring termination detector, bound into that module
// depends on rtd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rtd_checker import rtd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_word
);

   logic seen_done_ff;

   // a finished word was delivered; the node stays finished until reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_word.finished) begin
         seen_done_ff <= 1'b1;
      end
   end

   `RTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_word))
   `RTD_ASSERT_IMPLY(a_idle_token_zero, clock, reset, rsp_valid && !rsp_word.token_out_valid,
      rsp_word.token_out_count == '0 && !rsp_word.token_out_black)
   `RTD_ASSERT_IMPLY(a_bcast_finishes, clock, reset, rsp_valid && rsp_word.broadcast_terminate,
      rsp_word.finished && !rsp_word.token_out_valid)
   `RTD_ASSERT_IMPLY(a_done_sticky, clock, reset, rsp_valid && seen_done_ff,
      rsp_word.finished && !rsp_word.token_out_valid && !rsp_word.broadcast_terminate)

endmodule

bind ring_termination_detector rtd_checker u_rtd_checker (.*);

FILE: bench/rtd_checker.sv
`timescale 1ns / 1ps
// response checker for the ring termination detector: predicts each response word
// from the accepted event words and node id writes, then compares in order
// depends on rtd_pkg
module rtd_scoreboard import rtd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_word,
   input  logic                  csr_wr_en,
   input  logic [NODE_ID_W-1:0]  csr_wr_data,
   output int                    failures,
   output int                    pending,
   output int                    compared
);

   logic [NODE_ID_W-1:0]       node_id;
   logic signed [COUNT_W-1:0]  balance;
   logic                       node_black;
   logic                       active;
   logic                       holding;
   logic signed [COUNT_W-1:0]  held_count;
   logic                       held_black;
   logic                       done;

   rsp_type expected_q[$];

   function automatic logic signed [COUNT_W-1:0] clip_count(input int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return COUNT_W'(v);
   endfunction

   // passes the held token on; node 0 restarts the wave with a white zero token
   function automatic rsp_type pass_token();
      rsp_type                    r;
      logic signed [COUNT_W-1:0]  base;
      logic                       color;
      r = '0;
      base  = (node_id == 0) ? 16'sd0 : held_count;
      color = (node_id == 0) ? 1'b0 : held_black;
      r.token_out_valid = 1'b1;
      r.token_out_count = clip_count(int'(base) + int'(balance));
      r.token_out_black = color | node_black;
      node_black = 1'b0;
      holding    = 1'b0;
      return r;
   endfunction

   function automatic rsp_type next_response(input req_type w);
      rsp_type r;
      r = '0;
      if (done) begin
         r.finished = 1'b1;
         return r;
      end
      case (w.cmd)
         CMD_START: begin
            if (node_id == 0) r.token_out_valid = 1'b1;
         end
         CMD_TOKEN: begin
            holding    = 1'b1;
            held_count = w.token_in_count;
            held_black = w.token_in_black;
            if (!active) begin
               if (node_id == 0 && !w.token_in_black && w.token_in_count == 0) begin
                  holding = 1'b0;
                  done    = 1'b1;
                  r.broadcast_terminate = 1'b1;
               end else begin
                  r = pass_token();
               end
            end
         end
         CMD_TERMINATE: done = 1'b1;
         CMD_ACTIVE: active = 1'b1;
         CMD_PASSIVE: begin
            active = 1'b0;
            if (holding) r = pass_token();
         end
         CMD_SEND: begin
            balance = clip_count(int'(balance) + 1);
            if (node_id > w.peer) node_black = 1'b1;
         end
         CMD_RECEIVE: balance = clip_count(int'(balance) - 1);
         CMD_RESTART: begin
            node_black = 1'b0;
            balance    = '0;
         end
      endcase
      r.finished = done;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         node_id    = '0;
         balance    = '0;
         node_black = 1'b0;
         active     = 1'b0;
         holding    = 1'b0;
         held_count = '0;
         held_black = 1'b0;
         done       = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) node_id = csr_wr_data;
         if (req_valid && req_ready) expected_q.push_back(next_response(req_word));
         if (rsp_valid && rsp_ready) begin
            compared = compared + 1;
            if (expected_q.size() == 0) begin
               failures = failures + 1;
               if (failures <= 10)
                  $display("rtd_checker: response word %h with nothing expected", rsp_word);
            end else begin
               want = expected_q.pop_front();
               if (rsp_word !== want) begin
                  failures = failures + 1;
                  if (failures <= 10) begin
                     $write("rtd_checker: word %0d expected tok=%0b cnt=%0d blk=%0b term=%0b fin=%0b",
                            compared, want.token_out_valid, want.token_out_count,
                            want.token_out_black, want.broadcast_terminate, want.finished);
                     $display(", got tok=%0b cnt=%0d blk=%0b term=%0b fin=%0b",
                              rsp_word.token_out_valid, rsp_word.token_out_count,
                              rsp_word.token_out_black, rsp_word.broadcast_terminate,
                              rsp_word.finished);
                  end
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: bench/tb_ring_termination_detector.sv
`timescale 1ns / 1ps
// top of the ring termination detector bench: clock, reset, event stimulus, verdict
// depends on rtd_pkg, ring_termination_detector and rtd_scoreboard
module tb_ring_termination_detector;
   import rtd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [NODE_ID_W-1:0]  csr_wr_data = '0;

   int                    failures;
   int                    pending;
   int                    compared;
   int                    sent = 0;
   int                    rsp_hold = 0;
   bit                    idle_on = 1'b0;
   bit                    by_detection;
   logic [NODE_ID_W-1:0]  node_now = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ring_termination_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rtd_scoreboard i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending),
      .compared    (compared)
   );

   // random receiver back-pressure bursts while idle_on is set
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type ring_event(input cmd_type c, input logic [NODE_ID_W-1:0] p,
                                          input logic signed [COUNT_W-1:0] n, input logic b);
      req_type w;
      w.cmd            = c;
      w.peer           = p;
      w.token_in_count = n;
      w.token_in_black = b;
      return w;
   endfunction

   // small balances and values near the rails for half the picks, the rest anywhere
   function automatic logic signed [COUNT_W-1:0] pick_count();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 8) - 4;
         1: v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 2)
                                     : -32768 + $urandom_range(0, 2);
         default: v = $urandom;
      endcase
      return COUNT_W'(v);
   endfunction

   function automatic cmd_type pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return CMD_START;
      if (r < 33) return CMD_TOKEN;
      if (r < 47) return CMD_ACTIVE;
      if (r < 62) return CMD_PASSIVE;
      if (r < 78) return CMD_SEND;
      if (r < 92) return CMD_RECEIVE;
      return CMD_RESTART;
   endfunction

   function automatic req_type random_word(input cmd_type c);
      req_type w;
      w = ring_event(c, NODE_ID_W'($urandom), pick_count(), 1'($urandom));
      // a white zero token would end detection on node 0 for the rest of the run
      if (node_now == 0 && !w.token_in_black && w.token_in_count == 0)
         w.token_in_black = 1'b1;
      return w;
   endfunction

   task automatic push_event(input req_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_node_id(input logic [NODE_ID_W-1:0] id);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      node_now = id;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one busy period of a node followed by a token visit
   task automatic play_round();
      int n;
      if (node_now == 0 && $urandom_range(0, 1)) push_event(random_word(CMD_START));
      push_event(random_word(CMD_ACTIVE));
      n = $urandom_range(0, 4);
      repeat (n) push_event(random_word($urandom_range(0, 1) ? CMD_SEND : CMD_RECEIVE));
      if ($urandom_range(0, 2) == 0) push_event(random_word(CMD_TOKEN));
      push_event(random_word(CMD_PASSIVE));
      push_event(random_word(CMD_TOKEN));
   endtask

   initial begin
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // initiator: start, held token, reset on forward, black and nonzero tokens
      set_node_id(4'd0);
      push_event(ring_event(CMD_START, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_ACTIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_SEND, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_PASSIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd5, 1'b1));
      push_event(ring_event(CMD_RECEIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd0, 1'b1));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd7, 1'b0));

      // last node: blackening, token saturation, replaced token, idle passive
      set_node_id(4'd15);
      push_event(ring_event(CMD_SEND, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_SEND, 4'd15, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'h7fff, 1'b0));
      push_event(ring_event(CMD_RESTART, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_RECEIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'h8000, 1'b0));
      push_event(ring_event(CMD_START, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_ACTIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd100, 1'b1));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd3, 1'b0));
      push_event(ring_event(CMD_PASSIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_PASSIVE, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_SEND, 4'd3, 16'sd0, 1'b0));
      push_event(ring_event(CMD_RESTART, 4'd0, 16'sd0, 1'b0));
      push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd0, 1'b0));

      target = sent;
      for (int p = 0; p < 6; p++) begin
         case (p % 3)
            0: set_node_id(NODE_ID_W'(0));
            1: set_node_id(NODE_ID_W'(15));
            default: set_node_id(NODE_ID_W'($urandom_range(1, 14)));
         endcase
         idle_on <= (p != 2 && p != 5);
         target += 250;
         while (sent < target) begin
            if ($urandom_range(0, 9) < 7) play_round();
            else push_event(random_word(pick_cmd()));
         end
      end

      // finish the node, either by detection on node 0 or by a terminate word
      by_detection = $urandom_range(0, 1);
      idle_on <= 1'b0;
      set_node_id(by_detection ? NODE_ID_W'(0) : NODE_ID_W'($urandom_range(0, 15)));
      push_event(ring_event(CMD_PASSIVE, 4'd0, 16'sd0, 1'b0));
      if (by_detection) push_event(ring_event(CMD_TOKEN, 4'd0, 16'sd0, 1'b0));
      else push_event(ring_event(CMD_TERMINATE, 4'd0, 16'sd0, 1'b0));
      for (int c = 0; c < 8; c++) push_event(random_word(cmd_type'(c)));
      settle();
      repeat (8) @(posedge clock);

      $display("summary: %0d event words sent, %0d response words checked", sent, compared);
      $display("summary: node ids 0, 15 and random, token counts near both rails, ended by %s",
               by_detection ? "detection on node 0" : "a terminate word");
      if (failures == 0 && pending == 0) begin
         $display("tb_ring_termination_detector: done, clean");
      end else begin
         $display("tb_ring_termination_detector: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_ring_termination_detector: done, errors");
      $finish;
   end

endmodule
